// ----- src/tepq_pkg.sv -----
// Shared codes and controller/datapath interface types for the timed event queue.
package tepq_pkg;

    // Operation codes carried by the kind field
    localparam logic [1:0] KIND_INSERT  = 2'd0;
    localparam logic [1:0] KIND_CANCEL  = 2'd1;
    localparam logic [1:0] KIND_LOOKUP  = 2'd2;
    localparam logic [1:0] KIND_DEQUEUE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_DUP  = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr;     // write one invalid slot of the clearing sweep
        logic start;   // latch the incoming item, restart the slot scan
        logic scan;    // issue a read of the next slot
        logic finish;  // apply the operation and load the result registers
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic last_addr;  // slot address is at the last slot
    } t_stat;

endpackage

// ----- src/tepq_ctrl.sv -----
// Controller state machine: clearing sweep, slot scan sequencing and result handshake.
module tepq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  tepq_pkg::t_stat i_stat,
    output tepq_pkg::t_cmd  o_cmd
);
    import tepq_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_stall  = (r_state != S_IDLE);

    // Commands decoded from state
    always_comb begin
        o_cmd        = '0;
        o_cmd.clr    = (r_state == S_CLEAR);
        o_cmd.start  = (r_state == S_IDLE) && i_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.finish = (r_state == S_FINISH) && out_free;
    end

    // State and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.last_addr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (i_stat.last_addr) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

// ----- src/tepq_datapath.sv -----
// Datapath: slot memory, scan comparators, best-entry tracking and result registers.
module tepq_datapath #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 64,
    parameter int UID_BITS    = 40
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tepq_pkg::t_cmd  i_cmd,
    output tepq_pkg::t_stat o_stat,
    input  logic [1:0]      i_kind,
    input  logic [63:0]     i_event_time,
    input  logic [39:0]     i_event_uid,
    input  logic [31:0]     i_event_handle,
    output logic [1:0]      o_status,
    output logic [63:0]     o_out_time,
    output logic [39:0]     o_out_uid,
    output logic [31:0]     o_out_handle,
    output logic [6:0]      o_occupancy
);
    import tepq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] etime;
        logic [UID_BITS-1:0]  uid;
        logic [31:0]          handle;
    } t_entry;

    t_entry mem [QUEUE_DEPTH];

    // Latched item
    logic [1:0]           r_kind;
    logic [TIME_BITS-1:0] r_time;
    logic [UID_BITS-1:0]  r_uid;
    logic [31:0]          r_handle;

    // Scan state
    logic [AW-1:0] r_addr;
    t_entry        r_rd;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic          r_found;
    t_entry        r_best;
    logic [AW-1:0] r_best_idx;
    logic          r_dup;
    logic          r_free_ok;
    logic [AW-1:0] r_free_idx;
    logic [CW-1:0] r_count;

    // Result registers
    logic [1:0]           r_status;
    logic [TIME_BITS-1:0] r_out_time;
    logic [UID_BITS-1:0]  r_out_uid;
    logic [31:0]          r_out_handle;

    logic          exact;
    logic          filt;
    logic          earlier;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          is_ins;
    logic          full;
    logic [CW+6:0] count_ext;

    assign o_stat.last_addr = (r_addr == AW'(QUEUE_DEPTH - 1));

    // Compare of the slot just read against the item and the best so far
    always_comb begin
        exact   = (r_rd.etime == r_time) && (r_rd.uid == r_uid);
        earlier = (r_rd.etime < r_best.etime) ||
                  ((r_rd.etime == r_best.etime) && (r_rd.uid < r_best.uid));
        unique case (r_kind)
            KIND_CANCEL:  filt = exact;
            KIND_LOOKUP:  filt = (r_rd.uid == r_uid);
            KIND_DEQUEUE: filt = 1'b1;
            default:      filt = 1'b0;
        endcase
    end

    // Memory write selection: clearing sweep, insert or removal
    assign is_ins = (r_kind == KIND_INSERT);
    assign full   = (r_count == CW'(QUEUE_DEPTH));
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = r_best;
        wr_data.valid = 1'b0;
        if (i_cmd.clr) begin
            wr_en = 1'b1;
        end else if (i_cmd.finish) begin
            if (is_ins) begin
                wr_en   = !r_dup && !full;
                wr_addr = r_free_idx;
                wr_data = '{valid: 1'b1, etime: r_time, uid: r_uid, handle: r_handle};
            end else begin
                wr_en   = r_found && (r_kind != KIND_LOOKUP);
                wr_addr = r_best_idx;
            end
        end
    end

    // Slot memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd     <= mem[r_addr];
        r_rd_idx <= r_addr;
    end

    // Scan address, item latch and running results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_count  <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.start) begin
                r_addr <= '0;
            end else if (i_cmd.clr || i_cmd.scan) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.finish) begin
                if (is_ins) begin
                    if (!r_dup && !full) begin
                        r_count <= r_count + CW'(1);
                    end
                end else if (r_found && (r_kind != KIND_LOOKUP)) begin
                    r_count <= r_count - CW'(1);
                end
            end
        end
        if (i_cmd.start) begin
            r_kind    <= i_kind;
            r_time    <= i_event_time[TIME_BITS-1:0];
            r_uid     <= UID_BITS'(i_event_uid);
            r_handle  <= i_event_handle;
            r_found   <= 1'b0;
            r_dup     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_rd_vld) begin
            if (r_rd.valid) begin
                if (exact) begin
                    r_dup <= 1'b1;
                end
                if (filt && (!r_found || earlier)) begin
                    r_found    <= 1'b1;
                    r_best     <= r_rd;
                    r_best_idx <= r_rd_idx;
                end
            end else if (!r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
        // Result registers
        if (i_cmd.finish) begin
            r_out_time   <= '0;
            r_out_uid    <= '0;
            r_out_handle <= '0;
            if (is_ins) begin
                if (r_dup) begin
                    r_status <= ST_DUP;
                end else if (full) begin
                    r_status <= ST_FULL;
                end else begin
                    r_status <= ST_OK;
                end
            end else if (!r_found) begin
                r_status <= ST_NONE;
            end else begin
                r_status     <= ST_OK;
                r_out_time   <= r_best.etime;
                r_out_uid    <= r_best.uid;
                r_out_handle <= r_best.handle;
            end
        end
    end

    assign count_ext    = {7'b0, r_count};
    assign o_occupancy  = count_ext[6:0];
    assign o_status     = r_status;
    assign o_out_time   = 64'(r_out_time);
    assign o_out_uid    = 40'(r_out_uid);
    assign o_out_handle = r_out_handle;

endmodule

// ----- src/timed_event_priority_queue.sv -----
// Top level of the timed event queue: controller plus datapath.
// Holds up to QUEUE_DEPTH events ordered by time, then by id. Every item
// (insert, cancel, lookup, dequeue) is served by a scan of the slot memory,
// one slot per cycle through its single read port. An item is taken only
// while the queue is idle, so the next item is taken only after the result
// of the previous one has been loaded into the output register; a result
// still waiting in the output register holds the next result back.
// After reset a clearing sweep marks every slot empty; no item is taken
// during it.
module timed_event_priority_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 64,
    parameter int UID_BITS    = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_event_time,
    input  logic [39:0] i_event_uid,
    input  logic [31:0] i_event_handle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_out_time,
    output logic [39:0] o_out_uid,
    output logic [31:0] o_out_handle,
    output logic [6:0]  o_occupancy
);
    import tepq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tepq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    tepq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .UID_BITS    (UID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_kind),
        .i_event_time   (i_event_time),
        .i_event_uid    (i_event_uid),
        .i_event_handle (i_event_handle),
        .o_status       (o_status),
        .o_out_time     (o_out_time),
        .o_out_uid      (o_out_uid),
        .o_out_handle   (o_out_handle),
        .o_occupancy    (o_occupancy)
    );

endmodule
